// File: rtl/tmap_pkg.sv
// Shared constants for the HDR tone mapper: tone format, sRGB encode factors
// and the per-channel pipeline latency. No dependencies.
package tmap_pkg;

    localparam int TONE_BITS = 24;

    // linear segment: y <= 0.0031308, byte = 329460*y / (25*2^(TB+2))
    localparam longint unsigned LIN_MAX_Y  = (64'd31308 << TONE_BITS) / 64'd10000000;
    localparam int unsigned     LIN_MUL    = 329460;
    localparam int unsigned     LIN_RECIP  = 2622;
    localparam int              LIN_SHIFT  = 16;
    localparam int              LIN_DROP   = TONE_BITS + 2;

    // power segment: byte = (269025*u - 14025*2^TB) / (125*2^(TB+3))
    localparam int unsigned     POW_MUL    = 269025;
    localparam longint unsigned POW_SUB    = 64'd14025 << TONE_BITS;
    localparam int unsigned     POW_RECIP  = 67109;
    localparam int              POW_SHIFT  = 23;
    localparam int              POW_DROP   = TONE_BITS + 3;

    // register stages from input to output byte, per channel
    function automatic int chan_lat(input int frac_bits);
        return frac_bits + 87;
    endfunction

endpackage

// File: rtl/tmap_ifs.sv
// Channel interfaces for the tone mapper: pixel in, sRGB bytes out, config write.
// No dependencies.
interface tmap_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] red_sum;
    logic [31:0] green_sum;
    logic [31:0] blue_sum;
    logic [23:0] byte_offset;
    modport source (output valid, red_sum, green_sum, blue_sum, byte_offset, input ready);
    modport sink   (input valid, red_sum, green_sum, blue_sum, byte_offset, output ready);
endinterface

interface tmap_rgb_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
    logic [23:0] write_offset;
    modport source (output valid, red_byte, green_byte, blue_byte, write_offset, input ready);
    modport sink   (input valid, red_byte, green_byte, blue_byte, write_offset, output ready);
endinterface

interface tmap_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tmap_chan.sv
// One colour channel: average, filmic curve, sRGB encode to a byte.
// Bit-per-stage divide and root pipelines. Depends on tmap_pkg.
module tmap_chan #(
    parameter int F = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_div,
    input  logic [31:0] i_sum,
    output logic [7:0]  o_byte
);

    localparam int TB  = tmap_pkg::TONE_BITS;
    localparam int QW  = F + 3;
    localparam int NW  = 2 * F + 15;
    localparam int YW  = TB + 1;
    localparam int VW  = 2 * YW + 2;
    localparam int CR  = (2 * TB) / 3 + 1;
    localparam int CF  = (2 * TB) / 3;
    localparam int C3W = 3 * CR + 3;
    localparam int PW  = YW + 19;
    localparam int WPW = PW - tmap_pkg::POW_DROP;
    localparam int WLW = PW - tmap_pkg::LIN_DROP;
    localparam int QPW = WPW + 17;
    localparam int QLW = WLW + 12;

    // averaging divider
    logic [15:0]   r_dr   [QW+1];
    logic [QW-1:0] r_dq   [QW+1];
    logic [QW-1:0] r_dlo  [QW+1];
    logic          r_dsat [QW+1];
    logic [16:0]   w_dt   [QW];
    logic [16:0]   w_dsub [QW];
    logic          w_dge  [QW];
    logic [31:0]   w_hi;

    assign w_hi = i_sum >> QW;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_dt[k]   = {r_dr[k], r_dlo[k][QW-1]};
            w_dge[k]  = w_dt[k] >= {1'b0, i_div};
            w_dsub[k] = w_dt[k] - {1'b0, i_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsat[0] <= w_hi >= {16'd0, i_div};
            r_dr[0]   <= w_hi[15:0];
            r_dq[0]   <= '0;
            r_dlo[0]  <= i_sum[QW-1:0];
            for (int k = 0; k < QW; k++) begin
                r_dsat[k+1] <= r_dsat[k];
                r_dr[k+1]   <= w_dge[k] ? w_dsub[k][15:0] : w_dt[k][15:0];
                r_dq[k+1]   <= {r_dq[k][QW-2:0], w_dge[k]};
                r_dlo[k+1]  <= r_dlo[k] << 1;
            end
        end
    end

    // curve numerator and denominator
    logic [2*QW-1:0] r_sq;
    logic [QW-1:0]   r_x;
    logic            r_s1sat;
    logic [NW-1:0]   r_num;
    logic [NW-1:0]   r_den;
    logic            r_s2sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= (2*QW)'(r_dq[QW]) * (2*QW)'(r_dq[QW]);
            r_x     <= r_dq[QW];
            r_s1sat <= r_dsat[QW];
            r_num   <= NW'(251) * NW'(r_sq) + ((NW'(3) * NW'(r_x)) << F);
            r_den   <= NW'(243) * NW'(r_sq) + ((NW'(59) * NW'(r_x)) << F)
                     + (NW'(14) << (2 * F));
            r_s2sat <= r_s1sat;
        end
    end

    // curve divider, TB quotient bits
    logic [NW-1:0] r_cr   [TB+1];
    logic [NW-1:0] r_cd   [TB+1];
    logic [TB-1:0] r_cq   [TB+1];
    logic          r_csat [TB+1];
    logic [NW:0]   w_ct   [TB];
    logic [NW:0]   w_csub [TB];
    logic          w_cge  [TB];

    always_comb begin
        for (int k = 0; k < TB; k++) begin
            w_ct[k]   = {r_cr[k], 1'b0};
            w_cge[k]  = w_ct[k] >= {1'b0, r_cd[k]};
            w_csub[k] = w_ct[k] - {1'b0, r_cd[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr[0]   <= r_num;
            r_cd[0]   <= r_den;
            r_cq[0]   <= '0;
            r_csat[0] <= r_s2sat || (r_num >= r_den);
            for (int k = 0; k < TB; k++) begin
                r_cr[k+1]   <= w_cge[k] ? w_csub[k][NW-1:0] : w_ct[k][NW-1:0];
                r_cd[k+1]   <= r_cd[k];
                r_cq[k+1]   <= {r_cq[k][TB-2:0], w_cge[k]};
                r_csat[k+1] <= r_csat[k];
            end
        end
    end

    // a = isqrt(Y << TB)
    logic [YW-1:0]   r_ay   [TB+2];
    logic [2*YW-1:0] r_ay2  [TB+2];
    logic [YW-1:0]   r_av   [TB+2];
    logic            r_alin [TB+2];
    logic [VW-1:0]   w_at   [TB+1];
    logic            w_aok  [TB+1];
    logic [YW-1:0]   w_y;

    assign w_y = r_csat[TB] ? (YW'(1) << TB) : {1'b0, r_cq[TB]};

    always_comb begin
        for (int k = 0; k <= TB; k++) begin
            w_at[k]  = VW'(r_ay2[k]) + (VW'(r_ay[k]) << (TB - k + 1))
                     + (VW'(1) << (2 * (TB - k)));
            w_aok[k] = w_at[k] <= (VW'(r_av[k]) << TB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ay[0]   <= '0;
            r_ay2[0]  <= '0;
            r_av[0]   <= w_y;
            r_alin[0] <= 64'(w_y) <= tmap_pkg::LIN_MAX_Y;
            for (int k = 0; k <= TB; k++) begin
                r_ay[k+1]   <= w_aok[k] ? (r_ay[k] | (YW'(1) << (TB - k))) : r_ay[k];
                r_ay2[k+1]  <= w_aok[k] ? w_at[k][2*YW-1:0] : r_ay2[k];
                r_av[k+1]   <= r_av[k];
                r_alin[k+1] <= r_alin[k];
            end
        end
    end

    // b = isqrt(a << TB), c = icbrt(a << TB)
    logic [YW-1:0]   r_ba   [TB+2];
    logic [YW-1:0]   r_by   [TB+2];
    logic [2*YW-1:0] r_by2  [TB+2];
    logic [CR-1:0]   r_cy   [TB+2];
    logic [2*CR-1:0] r_cy2  [TB+2];
    logic [3*CR-1:0] r_cy3  [TB+2];
    logic [YW-1:0]   r_bv   [TB+2];
    logic            r_blin [TB+2];
    logic [VW-1:0]   w_bt   [TB+1];
    logic            w_bok  [TB+1];
    logic [C3W-1:0]  w_c3   [CR];
    logic [C3W-1:0]  w_c2   [CR];
    logic            w_cok  [CR];

    always_comb begin
        for (int k = 0; k <= TB; k++) begin
            w_bt[k]  = VW'(r_by2[k]) + (VW'(r_by[k]) << (TB - k + 1))
                     + (VW'(1) << (2 * (TB - k)));
            w_bok[k] = w_bt[k] <= (VW'(r_ba[k]) << TB);
        end
        for (int k = 0; k < CR; k++) begin
            w_c3[k]  = C3W'(r_cy3[k])
                     + ((C3W'(r_cy2[k]) * C3W'(3)) << (CR - 1 - k))
                     + ((C3W'(r_cy[k]) * C3W'(3)) << (2 * (CR - 1 - k)))
                     + (C3W'(1) << (3 * (CR - 1 - k)));
            w_c2[k]  = C3W'(r_cy2[k]) + (C3W'(r_cy[k]) << (CR - k))
                     + (C3W'(1) << (2 * (CR - 1 - k)));
            w_cok[k] = w_c3[k] <= (C3W'(r_ba[k]) << TB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ba[0]   <= r_ay[TB+1];
            r_by[0]   <= '0;
            r_by2[0]  <= '0;
            r_cy[0]   <= '0;
            r_cy2[0]  <= '0;
            r_cy3[0]  <= '0;
            r_bv[0]   <= r_av[TB+1];
            r_blin[0] <= r_alin[TB+1];
            for (int k = 0; k <= TB; k++) begin
                r_ba[k+1]   <= r_ba[k];
                r_by[k+1]   <= w_bok[k] ? (r_by[k] | (YW'(1) << (TB - k))) : r_by[k];
                r_by2[k+1]  <= w_bok[k] ? w_bt[k][2*YW-1:0] : r_by2[k];
                r_bv[k+1]   <= r_bv[k];
                r_blin[k+1] <= r_blin[k];
            end
            for (int k = 0; k < CR; k++) begin
                r_cy[k+1]  <= w_cok[k] ? (r_cy[k] | (CR'(1) << (CR - 1 - k))) : r_cy[k];
                r_cy2[k+1] <= w_cok[k] ? w_c2[k][2*CR-1:0] : r_cy2[k];
                r_cy3[k+1] <= w_cok[k] ? w_c3[k][3*CR-1:0] : r_cy3[k];
            end
            for (int k = CR; k <= TB; k++) begin
                r_cy[k+1]  <= r_cy[k];
                r_cy2[k+1] <= r_cy2[k];
                r_cy3[k+1] <= r_cy3[k];
            end
        end
    end

    // tail: u = b*c, scale, offset, divide by constant
    logic [YW+CR-1:0] w_bc;
    logic [YW-1:0]    r_u;
    logic [YW-1:0]    r_t1y;
    logic             r_t1lin;
    logic [PW-1:0]    r_t;
    logic [PW-1:0]    r_lp;
    logic             r_t2lin;
    logic [PW-1:0]    w_diff;
    logic [WPW-1:0]   r_wp;
    logic [WLW-1:0]   r_wl;
    logic             r_neg;
    logic             r_t3lin;
    logic [QPW-1:0]   w_qp;
    logic [QLW-1:0]   w_ql;
    logic [7:0]       n_byte;

    assign w_bc   = (YW+CR)'(r_by[TB+1]) * (YW+CR)'(r_cy[TB+1]);
    assign w_diff = r_t - PW'(tmap_pkg::POW_SUB);
    assign w_qp   = QPW'(r_wp) * QPW'(tmap_pkg::POW_RECIP);
    assign w_ql   = QLW'(r_wl) * QLW'(tmap_pkg::LIN_RECIP);

    always_comb begin
        if (r_t3lin) begin
            n_byte = w_ql[tmap_pkg::LIN_SHIFT +: 8];
        end else if (r_neg) begin
            n_byte = '0;
        end else if ((w_qp >> tmap_pkg::POW_SHIFT) > QPW'(255)) begin
            n_byte = 8'd255;
        end else begin
            n_byte = w_qp[tmap_pkg::POW_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u     <= w_bc[CF +: YW];
            r_t1y   <= r_bv[TB+1];
            r_t1lin <= r_blin[TB+1];
            r_t     <= PW'(r_u) * PW'(tmap_pkg::POW_MUL);
            r_lp    <= PW'(r_t1y) * PW'(tmap_pkg::LIN_MUL);
            r_t2lin <= r_t1lin;
            r_neg   <= r_t <= PW'(tmap_pkg::POW_SUB);
            r_wp    <= w_diff[PW-1:tmap_pkg::POW_DROP];
            r_wl    <= r_lp[PW-1:tmap_pkg::LIN_DROP];
            r_t3lin <= r_t2lin;
            o_byte  <= n_byte;
        end
    end

endmodule

// File: rtl/hdr_pixel_tonemap_to_srgb8_top.sv
// Top level of the HDR tone mapper to sRGB bytes.
// Depends on tmap_pkg, the interfaces in tmap_ifs.sv and tmap_chan.
//
// Usage:
//   i_pix carries one pixel's red, green and blue sample sums (UQ16.16) and its
//   byte offset; o_rgb returns the three encoded bytes and the offset. i_cfg
//   writes the sample count (0 is treated as 1); write it only while no
//   transaction is in flight. i_cfg is always ready.
//   Each channel averages, applies the filmic curve and sRGB encodes through a
//   pipeline of bit-per-stage dividers and root extractors.
//   Throughput: one pixel per cycle while o_rgb is not stalled.
//   Reset clears the pipeline valid bits and sets the sample count to 1.
//   When o_rgb is stalled the whole pipeline holds and i_pix.ready drops in the
//   same cycle; nothing is lost or repeated.
module hdr_pixel_tonemap_to_srgb8_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmap_cfg_if.sink   i_cfg,
    tmap_pix_if.sink   i_pix,
    tmap_rgb_if.source o_rgb
);

    localparam int LAT = tmap_pkg::chan_lat(FRACTION_BITS);

    logic [15:0]    r_sample_count;
    logic [15:0]    w_div;
    logic           w_en;
    logic [LAT-1:0] r_vld;
    logic [23:0]    r_off [LAT];

    assign i_cfg.ready = 1'b1;
    assign w_div       = (r_sample_count == 16'd0) ? 16'd1 : r_sample_count;
    assign w_en        = !r_vld[LAT-1] || o_rgb.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= 16'd1;
            r_vld          <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_sample_count <= i_cfg.data;
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_pix.valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_off[0] <= i_pix.byte_offset;
            for (int k = 1; k < LAT; k++) begin
                r_off[k] <= r_off[k-1];
            end
        end
    end

    tmap_chan #(.F(FRACTION_BITS)) u_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_div  (w_div),
        .i_sum  (i_pix.red_sum),
        .o_byte (o_rgb.red_byte)
    );

    tmap_chan #(.F(FRACTION_BITS)) u_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_div  (w_div),
        .i_sum  (i_pix.green_sum),
        .o_byte (o_rgb.green_byte)
    );

    tmap_chan #(.F(FRACTION_BITS)) u_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_div  (w_div),
        .i_sum  (i_pix.blue_sum),
        .o_byte (o_rgb.blue_byte)
    );

    assign o_rgb.valid        = r_vld[LAT-1];
    assign o_rgb.write_offset = r_off[LAT-1];

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb.valid && !o_rgb.ready) |-> !i_pix.ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted transaction missing from pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rgb.valid)
        else $error("output valid straight after reset");

endmodule
